### rtl/core/srsw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// srsw_pkg
// Types and fixed codes of the selective-repeat sender window.
// ============================================================================
package srsw_pkg;

    localparam int SEQ_W  = 31;
    localparam int LEN_W  = 10;
    localparam int TIME_W = 32;
    localparam int WIN_W  = 16;
    localparam int TMO_W  = 16;
    localparam int EV_W   = 3;
    localparam int OUTS_W = 5;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // input kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // result events
    localparam logic [EV_W-1:0] EV_SENT    = 3'd0;
    localparam logic [EV_W-1:0] EV_RESENT  = 3'd1;
    localparam logic [EV_W-1:0] EV_REFUSED = 3'd2;
    localparam logic [EV_W-1:0] EV_ACKED   = 3'd3;
    localparam logic [EV_W-1:0] EV_STARTED = 3'd4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_START   = 2'd2;

    localparam logic [WIN_W-1:0]  WINDOW_RST  = 16'd5120;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd500;
    localparam logic [SEQ_W-1:0]  START_RST   = 31'd5095;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] sent_time;
    } entry_t;

endpackage

### rtl/core/selective_repeat_sender_window.sv
`timescale 1ns / 1ps
// ============================================================================
// selective_repeat_sender_window
// Sender window of a selective-repeat transfer: keeps unacked blocks in send
// order in one entry memory, admits blocks against a byte window, removes
// acked entries and resends timed-out entries oldest first.
// ============================================================================
//
//  channel  | signals                                  | beat
//  ---------+------------------------------------------+-------------------------
//  in       | in_valid/in_ready, kind, block_len,      | one command
//           | ack_num                                  |
//  out      | out_valid/out_ready, event_res, seq_out, | one result, last marks
//           | len_out, outstanding, window_empty, last | the end of a command
//  cfg      | APB: psel, penable, pwrite, paddr,       | one register access
//           | pwdata, prdata, pready                   |
//
//  Start goes straight to the result state. Offer and ack walk the entry memory
//  one entry per cycle through its single read port; each read returns in the
//  read data register and is folded in the cycle after, and the result follows
//  the walk. A tick reads and checks each examined head entry in turn (read,
//  check). After reset the window is empty; no clearing pass is needed since
//  only entries below the fill count are read. A stalled output holds the
//  engine at its next result; a finished result waits in the output register
//  while the next command is taken.
// ============================================================================
module selective_repeat_sender_window
    import srsw_pkg::*;
#(
    parameter int MAX_ENTRIES  = 16,
    parameter int HEADER_BYTES = 8,
    parameter int MAX_PAYLOAD  = 1016
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [LEN_W-1:0]  block_len,
    input  logic [SEQ_W-1:0]  ack_num,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [EV_W-1:0]   event_res,
    output logic [SEQ_W-1:0]  seq_out,
    output logic [LEN_W-1:0]  len_out,
    output logic [OUTS_W-1:0] outstanding,
    output logic              window_empty,
    output logic              last,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int PTR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [CNT_W:0]   N_SUM  = (CNT_W+1)'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] N_CNT  = CNT_W'(MAX_ENTRIES);
    localparam logic [PTR_W-1:0] N_LAST = PTR_W'(MAX_ENTRIES - 1);
    localparam logic [SEQ_W-1:0] HDR_SEQ = SEQ_W'(HEADER_BYTES);
    localparam logic [SEQ_W+1:0] HDR_SPAN = (SEQ_W+2)'(HEADER_BYTES);
    localparam logic [16:0]      MAXP   = 17'(MAX_PAYLOAD);

    // engine states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;  // walk entries for offer or ack
    localparam logic [2:0] ST_FIN  = 3'd2;  // single result of start/offer/ack
    localparam logic [2:0] ST_T_RD = 3'd3;  // read queue head
    localparam logic [2:0] ST_T_CHK = 3'd4; // age check, rotate, emit

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIN_W-1:0] window_bytes_reg;
    logic [TMO_W-1:0] timeout_ticks_reg;
    logic [SEQ_W-1:0] start_seq_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_bytes_reg  <= WINDOW_RST;
            timeout_ticks_reg <= TIMEOUT_RST;
            start_seq_reg     <= START_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WINDOW:  window_bytes_reg  <= pwdata[WIN_W-1:0];
                REG_TIMEOUT: timeout_ticks_reg <= pwdata[TMO_W-1:0];
                REG_START:   start_seq_reg     <= pwdata[SEQ_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WINDOW:  prdata = {{(DATA_W-WIN_W){1'b0}}, window_bytes_reg};
            REG_TIMEOUT: prdata = {{(DATA_W-TMO_W){1'b0}}, timeout_ticks_reg};
            REG_START:   prdata = {{(DATA_W-SEQ_W){1'b0}}, start_seq_reg};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Entry memory: circular queue, head_reg is the oldest in send order
    // ------------------------------------------------------------------
    entry_t             entry_mem [MAX_ENTRIES];
    entry_t             rdata_reg;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= entry_mem[mem_raddr];
        end
    end

    // queue position to memory slot, one compare-subtract wrap
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W+1-PTR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= N_SUM)
        begin
            sum = sum - N_SUM;
        end
        return sum[PTR_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Engine state
    // ------------------------------------------------------------------
    logic [2:0]        state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [LEN_W-1:0]  blen_reg, blen_next;
    logic [SEQ_W-1:0]  ack_reg, ack_next;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [TIME_W-1:0] tick_clock_reg, tick_clock_next;
    logic [CNT_W-1:0]  rd_i_reg, rd_i_next;     // next entry to read
    logic [CNT_W-1:0]  w_reg, w_next;           // ack compaction write index
    logic              rd_pend_reg, rd_pend_next;
    logic [SEQ_W-1:0]  maxd_reg, maxd_next;     // farthest distance behind next_seq
    logic              pend_have_reg, pend_have_next;
    logic [SEQ_W-1:0]  pend_seq_reg, pend_seq_next;
    logic [LEN_W-1:0]  pend_len_reg, pend_len_next;

    logic              out_valid_reg, out_valid_next;
    logic [EV_W-1:0]   ev_reg, ev_next;
    logic [SEQ_W-1:0]  oseq_reg, oseq_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              olast_reg, olast_next;

    logic              in_acc;
    logic              out_free;
    logic [SEQ_W-1:0]  seq_gap;
    logic [SEQ_W+1:0]  span;
    logic              offer_ok;
    logic [TMO_W-1:0]  tmo;
    logic [TIME_W-1:0] age;
    logic              timed_out;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid & in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign seq_gap = next_seq_reg - rdata_reg.seq;
    assign span = {2'b00, maxd_reg} + (SEQ_W+2)'(blen_reg) + HDR_SPAN;
    assign offer_ok = ({7'd0, blen_reg} <= MAXP) && (cnt_reg < N_CNT) &&
                      (span <= {{(SEQ_W+2-WIN_W){1'b0}}, window_bytes_reg});
    assign tmo = (timeout_ticks_reg == '0) ? TMO_W'(1) : timeout_ticks_reg;
    assign age = tick_clock_reg - rdata_reg.sent_time;
    assign timed_out = (age >= {{(TIME_W-TMO_W){1'b0}}, tmo});

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        blen_next       = blen_reg;
        ack_next        = ack_reg;
        next_seq_next   = next_seq_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        tick_clock_next = tick_clock_reg;
        rd_i_next       = rd_i_reg;
        w_next          = w_reg;
        rd_pend_next    = 1'b0;
        maxd_next       = maxd_reg;
        pend_have_next  = pend_have_reg;
        pend_seq_next   = pend_seq_reg;
        pend_len_next   = pend_len_reg;

        out_valid_next  = out_valid_reg & ~out_ready;
        ev_next         = ev_reg;
        oseq_next       = oseq_reg;
        olen_next       = olen_reg;
        ocnt_next       = ocnt_reg;
        olast_next      = olast_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next = kind;
                    blen_next = block_len;
                    ack_next  = ack_num;
                    rd_i_next = '0;
                    w_next    = '0;
                    maxd_next = '0;
                    case (kind)
                        KIND_START: state_next = ST_FIN;
                        KIND_OFFER: state_next = ST_SCAN;
                        KIND_ACK:   state_next = ST_SCAN;
                        default:
                        begin
                            tick_clock_next = tick_clock_reg + TIME_W'(1);
                            pend_have_next  = 1'b0;
                            state_next      = (cnt_reg != '0) ? ST_T_RD : ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // one read issued per cycle, its data processed in the cycle after
                if (rd_pend_reg)
                begin
                    if (kind_reg == KIND_OFFER)
                    begin
                        if (seq_gap > maxd_reg)
                        begin
                            maxd_next = seq_gap;
                        end
                    end
                    else if (rdata_reg.seq != ack_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = slot_of(head_reg, w_reg);
                        w_next    = w_reg + CNT_W'(1);
                    end
                end
                if (rd_i_reg < cnt_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = slot_of(head_reg, rd_i_reg);
                    rd_i_next    = rd_i_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    olast_next     = 1'b1;
                    olen_next      = '0;
                    state_next     = ST_IDLE;
                    case (kind_reg)
                        KIND_START:
                        begin
                            cnt_next      = '0;
                            head_next     = '0;
                            next_seq_next = start_seq_reg + HDR_SEQ;
                            ev_next       = EV_STARTED;
                            oseq_next     = start_seq_reg + HDR_SEQ;
                            ocnt_next     = '0;
                        end
                        KIND_OFFER:
                        begin
                            oseq_next = next_seq_reg;
                            if (offer_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_of(head_reg, cnt_reg);
                                mem_wdata = '{seq: next_seq_reg, len: blen_reg,
                                              sent_time: tick_clock_reg};
                                cnt_next  = cnt_reg + CNT_W'(1);
                                ocnt_next = cnt_reg + CNT_W'(1);
                                next_seq_next = next_seq_reg + SEQ_W'(blen_reg) + HDR_SEQ;
                                ev_next   = EV_SENT;
                                olen_next = blen_reg;
                            end
                            else
                            begin
                                ev_next   = EV_REFUSED;
                                ocnt_next = cnt_reg;
                            end
                        end
                        default:
                        begin
                            cnt_next  = w_reg;
                            ev_next   = EV_ACKED;
                            oseq_next = ack_reg;
                            ocnt_next = w_reg;
                        end
                    endcase
                end
            end

            ST_T_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = head_reg;
                state_next = ST_T_CHK;
            end

            ST_T_CHK:
            begin
                // held resend goes out once we know whether another follows
                if (!pend_have_reg || out_free)
                begin
                    if (pend_have_reg)
                    begin
                        out_valid_next = 1'b1;
                        ev_next        = EV_RESENT;
                        oseq_next      = pend_seq_reg;
                        olen_next      = pend_len_reg;
                        ocnt_next      = cnt_reg;
                        olast_next     = ~timed_out;
                    end
                    if (timed_out)
                    begin
                        // move head to the back with a fresh send time
                        mem_we    = 1'b1;
                        mem_waddr = slot_of(head_reg, cnt_reg);
                        mem_wdata = '{seq: rdata_reg.seq, len: rdata_reg.len,
                                      sent_time: tick_clock_reg};
                        head_next = (head_reg == N_LAST) ? '0 : head_reg + PTR_W'(1);
                        pend_have_next = 1'b1;
                        pend_seq_next  = rdata_reg.seq;
                        pend_len_next  = rdata_reg.len;
                        state_next     = ST_T_RD;
                    end
                    else
                    begin
                        pend_have_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            next_seq_reg   <= START_RST + HDR_SEQ;
            cnt_reg        <= '0;
            head_reg       <= '0;
            tick_clock_reg <= '0;
            rd_i_reg       <= '0;
            w_reg          <= '0;
            rd_pend_reg    <= 1'b0;
            pend_have_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_seq_reg   <= next_seq_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
            tick_clock_reg <= tick_clock_next;
            rd_i_reg       <= rd_i_next;
            w_reg          <= w_next;
            rd_pend_reg    <= rd_pend_next;
            pend_have_reg  <= pend_have_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        blen_reg     <= blen_next;
        ack_reg      <= ack_next;
        maxd_reg     <= maxd_next;
        pend_seq_reg <= pend_seq_next;
        pend_len_reg <= pend_len_next;
        ev_reg       <= ev_next;
        oseq_reg     <= oseq_next;
        olen_reg     <= olen_next;
        ocnt_reg     <= ocnt_next;
        olast_reg    <= olast_next;
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = ev_reg;
    assign seq_out      = oseq_reg;
    assign len_out      = olen_reg;
    assign outstanding  = OUTS_W'(ocnt_reg);
    assign window_empty = (ocnt_reg == '0);
    assign last         = olast_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= N_CNT)
        else $error("entry count above store depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= N_LAST)
        else $error("queue head outside memory");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (w_reg <= rd_i_reg) && (rd_i_reg <= cnt_reg))
        else $error("scan indexes out of order");

    a_no_held_resend: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_have_reg)
        else $error("held resend lost at command end");

    a_tick_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_T_CHK) |=> (cnt_reg == $past(cnt_reg)))
        else $error("resend changed entry count");

endmodule
